[src/debounced_input_latch_counter_defines.svh]
// ----------------------------------------------------------------------------
// debounced_input_latch_counter_defines.svh
// Assertion macros shared by the debounced input latch counter RTL.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_INPUT_LATCH_COUNTER_DEFINES_SVH
`define DEBOUNCED_INPUT_LATCH_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DILC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DILC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

[src/dilc_pkg.sv]
// ----------------------------------------------------------------------------
// dilc_pkg
// Shared types and constants of the debounced input latch counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dilc_pkg;

	localparam int DEF_CHANNELS   = 4;
	localparam int DEF_COUNT_BITS = 32;

	// Fixed field widths of the channels
	localparam int OP_W       = 3;
	localparam int LVL_W      = 4;
	localparam int CH_W       = 2;
	localparam int MASK_W     = 4;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_BIT_W  = 4;
	localparam int THR_W      = 8;
	localparam int DIFF_W     = 8;

	localparam logic [THR_W-1:0]  THR_RESET = 8'd5;
	localparam logic [DIFF_W-1:0] DIFF_MAX  = 8'd255;

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE     = 3'd0,
		OP_CLR_COUNT  = 3'd1,
		OP_CLR_LATCH  = 3'd2,
		OP_CLR_OVF    = 3'd3,
		OP_WRITE_MASK = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LATCH_ON_RISING    = 2'd0,
		REG_COUNT_ENABLE       = 2'd1,
		REG_DEBOUNCE_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_BIT_W-1:0] latch_on_rising;
		logic [CFG_BIT_W-1:0] count_enable;
		logic [THR_W-1:0]     threshold;
	} cfg_t;

	// Per-channel command for one advancing word
	typedef struct packed {
		logic             sample;
		logic             raw;
		logic             clr_count;
		logic             clr_latch;
		logic             clr_ovf;
		logic             wr_latch;
		logic             wr_val;
		logic             latch_rise;
		logic             cnt_en;
		logic [THR_W-1:0] threshold;
	} chan_ctl_t;

endpackage

`default_nettype wire

[src/dilc_in_if.sv]
// ----------------------------------------------------------------------------
// dilc_in_if
// Input word channel: operation and its operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface dilc_in_if
	import dilc_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [LVL_W-1:0]  pin_levels;
	logic [CH_W-1:0]   channel;
	logic [MASK_W-1:0] latch_mask;

	modport source (output valid, operation, pin_levels, channel, latch_mask, input ready);
	modport sink   (input valid, operation, pin_levels, channel, latch_mask, output ready);
endinterface

`default_nettype wire

[src/dilc_out_if.sv]
// ----------------------------------------------------------------------------
// dilc_out_if
// Result word channel: levels, flags and selected pulse count.
// ----------------------------------------------------------------------------
`default_nettype none

interface dilc_out_if
	import dilc_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [LVL_W-1:0] stable_levels;
	logic [LVL_W-1:0] latch_flags;
	logic [LVL_W-1:0] overflow_flags;
	logic [CNT_W-1:0] count_value;

	modport source (output valid, stable_levels, latch_flags, overflow_flags, count_value,
		input ready);
	modport sink   (input valid, stable_levels, latch_flags, overflow_flags, count_value,
		output ready);
endinterface

`default_nettype wire

[src/dilc_cfg_if.sv]
// ----------------------------------------------------------------------------
// dilc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dilc_cfg_if
	import dilc_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/debounced_input_latch_counter.sv]
// ----------------------------------------------------------------------------
// debounced_input_latch_counter
// Debounced digital inputs with edge latches and falling-edge pulse counters.
// ----------------------------------------------------------------------------
// Usage:
//   din  - one word per operation: sample tick (pin_levels), clear counter,
//          clear latch, clear overflow (channel), write latch mask.
//   dout - one word per input word: stable levels, latch flags, overflow
//          flags and the pulse count of the word's channel, all after the
//          operation took effect.
//   cfg  - register writes (latch_on_rising, count_enable,
//          debounce_threshold); always ready, write only while idle.
// Pipeline: an accepted word waits in one input register, then updates the
//   channel state, which is the result shown on dout.
// Throughput: one word per cycle while dout is not stalled, set by the single
//   input stage feeding the per-channel update logic.
// Stall: while dout is held, the channel state is frozen and the input stage
//   keeps one more word; din.ready drops only when both are full.
// Reset: arst_n clears all levels, counts, flags and the pipeline; config
//   returns to latch on fall, counting off, threshold 5.
// ----------------------------------------------------------------------------
`default_nettype none

`include "debounced_input_latch_counter_defines.svh"

module debounced_input_latch_counter
	import dilc_pkg::*;
#(
	parameter int CHANNELS   = DEF_CHANNELS,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dilc_in_if.sink    din,
	dilc_out_if.source dout,
	dilc_cfg_if.sink   cfg
);

	// Padded width so the fixed 4-bit fields map onto any channel count
	localparam int PAD_W = (CHANNELS > LVL_W) ? CHANNELS : LVL_W;

	cfg_t regs;

	dilc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// ---- input stage ----
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [LVL_W-1:0]  pins_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [MASK_W-1:0] mask_s1;

	logic out_valid_q;
	logic [CHANNELS-1:0] out_sel_q;   // one-hot readback channel, zero if out of range

	logic advance;
	logic in_acc;

	assign advance   = valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || advance;
	assign in_acc    = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= din.operation;
			pins_s1 <= din.pin_levels;
			ch_s1   <= din.channel;
			mask_s1 <= din.latch_mask;
		end
	end

	// ---- operation decode, qualified by advance ----
	logic is_sample, is_clr_count, is_clr_latch, is_clr_ovf, is_wr_mask;

	always_comb begin
		is_sample    = 1'b0;
		is_clr_count = 1'b0;
		is_clr_latch = 1'b0;
		is_clr_ovf   = 1'b0;
		is_wr_mask   = 1'b0;
		unique case (op_t'(op_s1))
			OP_SAMPLE:     is_sample    = advance;
			OP_CLR_COUNT:  is_clr_count = advance;
			OP_CLR_LATCH:  is_clr_latch = advance;
			OP_CLR_OVF:    is_clr_ovf   = advance;
			OP_WRITE_MASK: is_wr_mask   = advance;
			default: begin
			end
		endcase
	end

	logic [PAD_W-1:0] pins_pad, mask_pad, rise_pad, cen_pad;
	assign pins_pad = PAD_W'(pins_s1);
	assign mask_pad = PAD_W'(mask_s1);
	assign rise_pad = PAD_W'(regs.latch_on_rising);
	assign cen_pad  = PAD_W'(regs.count_enable);

	// ---- channel array ----
	logic [CHANNELS-1:0]   sel_s1;
	logic [CHANNELS-1:0]   stable_v, latch_v, ovf_v;
	logic [COUNT_BITS-1:0] count_v [CHANNELS];

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		chan_ctl_t ctl;

		assign sel_s1[c] = (int'(ch_s1) == c);

		always_comb begin
			ctl.sample     = is_sample;
			ctl.raw        = pins_pad[c];
			ctl.clr_count  = is_clr_count && sel_s1[c];
			ctl.clr_latch  = is_clr_latch && sel_s1[c];
			ctl.clr_ovf    = is_clr_ovf && sel_s1[c];
			ctl.wr_latch   = is_wr_mask;
			ctl.wr_val     = mask_pad[c];
			ctl.latch_rise = rise_pad[c];
			ctl.cnt_en     = cen_pad[c];
			ctl.threshold  = regs.threshold;
		end

		dilc_chan #(
			.COUNT_BITS (COUNT_BITS)
		) u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.stable (stable_v[c]),
			.latch  (latch_v[c]),
			.ovf    (ovf_v[c]),
			.count  (count_v[c])
		);
	end

	// ---- result stage: valid and readback select; the channel state is the data ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_sel_q <= sel_s1;
		end
	end

	logic [COUNT_BITS-1:0] count_mux;
	logic [PAD_W-1:0]      stable_pad, latch_pad, ovf_pad;

	always_comb begin
		count_mux = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			count_mux = count_mux | (out_sel_q[c] ? count_v[c] : '0);
		end
	end

	assign stable_pad = PAD_W'(stable_v);
	assign latch_pad  = PAD_W'(latch_v);
	assign ovf_pad    = PAD_W'(ovf_v);

	assign dout.valid          = out_valid_q;
	assign dout.stable_levels  = stable_pad[LVL_W-1:0];
	assign dout.latch_flags    = latch_pad[LVL_W-1:0];
	assign dout.overflow_flags = ovf_pad[LVL_W-1:0];
	assign dout.count_value    = CNT_W'(count_mux);

	`DILC_ASSERT_NEXT(a_state_held_on_stall, clk, arst_n, out_valid_q && !dout.ready,
		$stable(stable_v) && $stable(latch_v) && $stable(ovf_v),
		"channel state changed while result was stalled")
	`DILC_ASSERT_NOW(a_no_accept_when_full, clk, arst_n,
		valid_s1 && out_valid_q && !dout.ready, !din.ready,
		"input accepted with both stages full")
	`DILC_ASSERT_NOW(a_sel_onehot0, clk, arst_n, out_valid_q, $onehot0(out_sel_q),
		"readback select not one-hot")

endmodule

`default_nettype wire

[src/dilc_cfg.sv]
// ----------------------------------------------------------------------------
// dilc_cfg
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dilc_cfg
	import dilc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	dilc_cfg_if.sink    cfg,
	output cfg_t        regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.latch_on_rising <= '0;
			regs_q.count_enable    <= '0;
			regs_q.threshold       <= THR_RESET;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_LATCH_ON_RISING: begin
					regs_q.latch_on_rising <= cfg.data[CFG_BIT_W-1:0];
				end
				REG_COUNT_ENABLE: begin
					regs_q.count_enable <= cfg.data[CFG_BIT_W-1:0];
				end
				REG_DEBOUNCE_THRESHOLD: begin
					regs_q.threshold <= cfg.data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[src/dilc_chan.sv]
// ----------------------------------------------------------------------------
// dilc_chan
// One input channel: debounce counter, stable level, latch, pulse counter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "debounced_input_latch_counter_defines.svh"

module dilc_chan
	import dilc_pkg::*;
#(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire chan_ctl_t             ctl,
	output logic                       stable,
	output logic                       latch,
	output logic                       ovf,
	output logic [COUNT_BITS-1:0]      count
);

	logic [DIFF_W-1:0]     diff_q;
	logic                  stable_q;
	logic                  latch_q;
	logic                  ovf_q;
	logic [COUNT_BITS-1:0] count_q;

	logic [DIFF_W-1:0]     diff_nx;
	logic                  change;
	logic [COUNT_BITS-1:0] count_inc;

	always_comb begin
		if (ctl.raw != stable_q) begin
			diff_nx = (diff_q == DIFF_MAX) ? diff_q : diff_q + DIFF_W'(1);
		end else begin
			diff_nx = '0;
		end
		change    = diff_nx > ctl.threshold;
		count_inc = count_q + COUNT_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q   <= '0;
			stable_q <= 1'b0;
			latch_q  <= 1'b0;
			ovf_q    <= 1'b0;
			count_q  <= '0;
		end else begin
			if (ctl.sample) begin
				diff_q <= diff_nx;
				if (change) begin
					stable_q <= ctl.raw;
					if (ctl.raw) begin
						if (ctl.latch_rise) begin
							latch_q <= 1'b1;
						end
					end else begin
						if (ctl.cnt_en) begin
							count_q <= count_inc;
							if (count_inc == '0) begin
								ovf_q <= 1'b1;
							end
						end
						if (!ctl.latch_rise) begin
							latch_q <= 1'b1;
						end
					end
				end
			end
			if (ctl.clr_count) begin
				count_q <= '0;
			end
			if (ctl.clr_latch) begin
				latch_q <= 1'b0;
			end
			if (ctl.clr_ovf) begin
				ovf_q <= 1'b0;
			end
			if (ctl.wr_latch) begin
				latch_q <= ctl.wr_val;
			end
		end
	end

	assign stable = stable_q;
	assign latch  = latch_q;
	assign ovf    = ovf_q;
	assign count  = count_q;

	`DILC_ASSERT_NEXT(a_clr_count, clk, arst_n, ctl.clr_count, count_q == '0,
		"pulse counter not cleared")
	`DILC_ASSERT_NEXT(a_level_only_on_sample, clk, arst_n, !ctl.sample, $stable(stable_q),
		"stable level moved without a sample tick")
	`DILC_ASSERT_NOW(a_ovf_from_count, clk, arst_n, $rose(ovf_q),
		$past(ctl.sample) && $past(ctl.cnt_en) && ($past(count_q) == '1),
		"overflow flag set without a counter wrap")

endmodule

`default_nettype wire

[dv/tb_debounced_input_latch_counter.sv]
// ----------------------------------------------------------------------------
// tb_debounced_input_latch_counter
// Self-checking bench for the debounced input latch counter.
// ----------------------------------------------------------------------------
// A short table of directed words runs first. Rows whose result is plain
// carry it typed in; the other rows go through the predictor. Several
// register phases of random words follow. Each phase mostly holds pin levels
// long enough to pass the debounce threshold, with glitches and short holds
// mixed in. Every accepted word is predicted at once. Every result word is
// checked against the oldest prediction. Sender and receiver stall at random
// in two of three idle regimes; the third runs with no idling.
// ----------------------------------------------------------------------------

module tb_debounced_input_latch_counter;
	import dilc_pkg::*;

	// Operation codes the block does not define; they must leave state alone
	localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
	// Register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int N_CH        = DEF_CHANNELS;
	localparam int DIR_N       = 21;
	localparam int PHASES      = 8;
	localparam int STALL_LIMIT = 3000;
	localparam int MAX_REPORTS = 10;
	// Boundaries between idle regimes, counted in words sent
	localparam int MODE1_AT    = 690;
	localparam int MODE2_AT    = 1380;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [LVL_W-1:0]  levels;
		logic [CH_W-1:0]   ch;
		logic [MASK_W-1:0] mask;
	} word_t;

	typedef struct packed {
		logic [LVL_W-1:0] stable;
		logic [LVL_W-1:0] latch;
		logic [LVL_W-1:0] ovf;
		logic [CNT_W-1:0] count;
	} status_t;

	typedef struct packed {
		word_t   w;
		logic    known;
		status_t exp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	dilc_in_if  din_if ();
	dilc_out_if dout_if ();
	dilc_cfg_if cfg_if ();

	debounced_input_latch_counter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state and its copy of the registers
	logic [LVL_W-1:0]  m_stable;
	logic [LVL_W-1:0]  m_latch;
	logic [LVL_W-1:0]  m_wrap;
	logic [DIFF_W-1:0] m_diff [N_CH];
	logic [CNT_W-1:0]  m_pulse [N_CH];
	logic [CFG_BIT_W-1:0] m_lor;
	logic [CFG_BIT_W-1:0] m_cnt_en;
	logic [THR_W-1:0]     m_thr;

	status_t status_q [$];
	int      errors = 0;
	int      words_sent = 0;
	int      send_idle = 0;
	int      recv_idle = 0;
	int      stall_cycles = 0;
	logic    cur_known = 1'b0;
	status_t cur_exp = '0;

	// Random stream state: level pattern being held and samples left in the hold
	logic [LVL_W-1:0] gen_lv = '0;
	int               gen_left = 0;
	int               ph_thr = THR_RESET;

	// Directed words; reset defaults apply (latch on fall, no counting, threshold 5)
	dir_row_t dir_rows [DIR_N] = '{
		'{'{OP_RSVD_7,     4'hF, 2'd3, 4'hF}, 1'b1, '{4'h0, 4'h0, 4'h0, 32'd0}},
		'{'{OP_WRITE_MASK, 4'h0, 2'd0, 4'hF}, 1'b1, '{4'h0, 4'hF, 4'h0, 32'd0}},
		'{'{OP_CLR_LATCH,  4'h0, 2'd3, 4'h0}, 1'b1, '{4'h0, 4'h7, 4'h0, 32'd0}},
		'{'{OP_WRITE_MASK, 4'hF, 2'd1, 4'h0}, 1'b1, '{4'h0, 4'h0, 4'h0, 32'd0}},
		'{'{OP_CLR_OVF,    4'hF, 2'd0, 4'hF}, 1'b1, '{4'h0, 4'h0, 4'h0, 32'd0}},
		'{'{OP_CLR_COUNT,  4'hF, 2'd2, 4'hF}, 1'b1, '{4'h0, 4'h0, 4'h0, 32'd0}},
		// five differing samples: count reaches the threshold, not past it
		'{'{OP_SAMPLE,     4'hF, 2'd0, 4'h0}, 1'b1, '{4'h0, 4'h0, 4'h0, 32'd0}},
		'{'{OP_SAMPLE,     4'hF, 2'd1, 4'h0}, 1'b1, '{4'h0, 4'h0, 4'h0, 32'd0}},
		'{'{OP_SAMPLE,     4'hF, 2'd2, 4'h0}, 1'b1, '{4'h0, 4'h0, 4'h0, 32'd0}},
		'{'{OP_SAMPLE,     4'hF, 2'd3, 4'h0}, 1'b1, '{4'h0, 4'h0, 4'h0, 32'd0}},
		'{'{OP_SAMPLE,     4'hF, 2'd0, 4'h0}, 1'b1, '{4'h0, 4'h0, 4'h0, 32'd0}},
		// sixth one flips all levels high; rise does not latch here
		'{'{OP_SAMPLE,     4'hF, 2'd1, 4'h0}, 1'b1, '{4'hF, 4'h0, 4'h0, 32'd0}},
		// count was kept, so one low sample drops the level right away
		'{'{OP_SAMPLE,     4'h0, 2'd2, 4'h0}, 1'b0, '0},
		'{'{OP_SAMPLE,     4'h0, 2'd3, 4'h0}, 1'b0, '0},
		'{'{OP_RSVD_5,     4'hA, 2'd1, 4'h5}, 1'b0, '0},
		'{'{OP_WRITE_MASK, 4'h5, 2'd2, 4'hA}, 1'b0, '0},
		'{'{OP_CLR_LATCH,  4'h0, 2'd1, 4'hF}, 1'b0, '0},
		'{'{OP_CLR_COUNT,  4'hA, 2'd3, 4'h0}, 1'b0, '0},
		'{'{OP_SAMPLE,     4'hA, 2'd0, 4'h5}, 1'b0, '0},
		'{'{OP_CLR_OVF,    4'h5, 2'd2, 4'hA}, 1'b0, '0},
		'{'{OP_RSVD_6,     4'h3, 2'd1, 4'hC}, 1'b0, '0}
	};

	// Register phases; random fields are drawn when the phase starts
	int         ph_items [PHASES] = '{200, 200, 200, 450, 400, 200, 200, 200};
	logic [7:0] ph_lor   [PHASES] = '{8'h00, 8'hFF, 8'h05, 8'h00, 8'h0A, 8'h00, 8'h00, 8'h0F};
	logic [7:0] ph_ce    [PHASES] = '{8'h0F, 8'hFF, 8'h0A, 8'h00, 8'h05, 8'h00, 8'h00, 8'hF0};
	logic [7:0] ph_thrv  [PHASES] = '{8'd0, 8'd1, 8'd3, 8'd254, 8'd255, 8'd0, 8'd2, 8'd6};
	bit         ph_rbits [PHASES] = '{0, 0, 0, 1, 0, 1, 1, 0};
	bit         ph_rthr  [PHASES] = '{0, 0, 0, 0, 0, 1, 0, 0};
	bit         ph_unusd [PHASES] = '{0, 0, 0, 0, 0, 0, 1, 0};

	// Status after one word: levels, flags and the selected pulse count
	function automatic status_t next_status(input word_t w);
		status_t s;
		int      ch;
		case (w.op)
			OP_SAMPLE: begin
				for (ch = 0; ch < N_CH; ch++) begin
					if (w.levels[ch] != m_stable[ch]) begin
						if (m_diff[ch] != DIFF_MAX)
							m_diff[ch] = m_diff[ch] + 1'b1;
					end else begin
						m_diff[ch] = '0;
					end
				end
				for (ch = 0; ch < N_CH; ch++) begin
					if (m_diff[ch] > m_thr) begin
						if (w.levels[ch]) begin
							m_stable[ch] = 1'b1;
							if (m_lor[ch])
								m_latch[ch] = 1'b1;
						end else begin
							m_stable[ch] = 1'b0;
							if (m_cnt_en[ch]) begin
								m_pulse[ch] = m_pulse[ch] + 1'b1;
								if (m_pulse[ch] == '0)
									m_wrap[ch] = 1'b1;
							end
							if (!m_lor[ch])
								m_latch[ch] = 1'b1;
						end
					end
				end
			end
			OP_CLR_COUNT:  m_pulse[w.ch] = '0;
			OP_CLR_LATCH:  m_latch[w.ch] = 1'b0;
			OP_CLR_OVF:    m_wrap[w.ch] = 1'b0;
			OP_WRITE_MASK: m_latch = w.mask;
			default: ;
		endcase
		s.stable = m_stable;
		s.latch  = m_latch;
		s.ovf    = m_wrap;
		s.count  = m_pulse[w.ch];
		return s;
	endfunction

	// Mostly held level patterns so the debounce gets through, plus noise
	function automatic word_t rand_word();
		word_t w;
		int    pick;
		w.op     = OP_SAMPLE;
		w.ch     = CH_W'($urandom);
		w.mask   = MASK_W'($urandom);
		w.levels = gen_lv;
		pick     = $urandom_range(0, 99);
		if (pick < 78) begin
			if (gen_left == 0) begin
				gen_lv = LVL_W'($urandom);
				// a quarter of the holds are short; most of those are too short to flip a level
				if ($urandom_range(0, 3) == 0)
					gen_left = $urandom_range(1, ph_thr + 1);
				else
					gen_left = ph_thr + $urandom_range(1, 4);
			end
			gen_left--;
			w.levels = gen_lv;
			if (ph_thr < 16 && $urandom_range(0, 19) == 0)
				w.levels = w.levels ^ (4'b0001 << $urandom_range(0, 3));
		end else begin
			// long holds are not broken by stray samples in slow phases
			if (ph_thr < 16)
				w.op = OP_W'($urandom_range(0, 7));
			else
				w.op = OP_W'($urandom_range(1, 7));
			w.levels = LVL_W'($urandom);
		end
		return w;
	endfunction

	task automatic send_word(input word_t w, input logic known, input status_t exp);
		if (words_sent < MODE1_AT) begin
			send_idle = 23;
			recv_idle = 87;
		end else if (words_sent < MODE2_AT) begin
			send_idle = 87;
			recv_idle = 23;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			din_if.valid = 1'b0;
			@(negedge clk);
		end
		din_if.valid      = 1'b1;
		din_if.operation  = w.op;
		din_if.pin_levels = w.levels;
		din_if.channel    = w.ch;
		din_if.latch_mask = w.mask;
		cur_known         = known;
		cur_exp           = exp;
		do
			@(posedge clk);
		while (!din_if.ready);
		words_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = data;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// Stop sending and wait for every predicted word to come back
	task automatic drain();
		@(negedge clk);
		din_if.valid = 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Receiver back-pressure
	always @(negedge clk) begin
		if (!arst_n)
			dout_if.ready = 1'b0;
		else
			dout_if.ready = ($urandom_range(0, 99) >= recv_idle);
	end

	// Scoreboard: results first, then register writes, then predictions for words taken this edge
	always @(posedge clk) begin
		status_t got;
		status_t want;
		word_t   w;
		if (arst_n) begin
			if (dout_if.valid && dout_if.ready) begin
				got.stable = dout_if.stable_levels;
				got.latch  = dout_if.latch_flags;
				got.ovf    = dout_if.overflow_flags;
				got.count  = dout_if.count_value;
				if (status_q.size() == 0) begin
					if (errors < MAX_REPORTS)
						$display("unexpected result word: stable %h latch %h ovf %h count %h",
							got.stable, got.latch, got.ovf, got.count);
					errors++;
				end else begin
					want = status_q.pop_front();
					if (got.stable !== want.stable || got.latch !== want.latch ||
						got.ovf !== want.ovf || got.count !== want.count) begin
						if (errors < MAX_REPORTS)
							$display({"mismatch: expected stable %h latch %h ovf %h count %h,",
								" got stable %h latch %h ovf %h count %h"},
								want.stable, want.latch, want.ovf, want.count,
								got.stable, got.latch, got.ovf, got.count);
						errors++;
					end
				end
			end
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_LATCH_ON_RISING:    m_lor    = cfg_if.data[CFG_BIT_W-1:0];
					REG_COUNT_ENABLE:       m_cnt_en = cfg_if.data[CFG_BIT_W-1:0];
					REG_DEBOUNCE_THRESHOLD: m_thr    = cfg_if.data[THR_W-1:0];
					default: ;
				endcase
			end
			if (din_if.valid && din_if.ready) begin
				w.op     = din_if.operation;
				w.levels = din_if.pin_levels;
				w.ch     = din_if.channel;
				w.mask   = din_if.latch_mask;
				want     = next_status(w);
				if (cur_known)
					want = cur_exp;
				status_q.push_back(want);
			end
		end
	end

	// Watchdog on cycles where no channel moves a word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_debounced_input_latch_counter NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int         i;
		int         ph;
		int         n;
		logic [7:0] d_lor;
		logic [7:0] d_ce;
		logic [7:0] d_thr;
		arst_n            = 1'b0;
		din_if.valid      = 1'b0;
		din_if.operation  = OP_SAMPLE;
		din_if.pin_levels = '0;
		din_if.channel    = '0;
		din_if.latch_mask = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = REG_LATCH_ON_RISING;
		cfg_if.data       = '0;
		m_stable = '0;
		m_latch  = '0;
		m_wrap   = '0;
		for (i = 0; i < N_CH; i++) begin
			m_diff[i]  = '0;
			m_pulse[i] = '0;
		end
		m_lor    = '0;
		m_cnt_en = '0;
		m_thr    = THR_RESET;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < DIR_N; i++)
			send_word(dir_rows[i].w, dir_rows[i].known, dir_rows[i].exp);

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			d_lor = ph_rbits[ph] ? 8'($urandom) : ph_lor[ph];
			d_ce  = ph_rbits[ph] ? 8'($urandom) : ph_ce[ph];
			d_thr = ph_rthr[ph] ? 8'($urandom_range(0, 8)) : ph_thrv[ph];
			write_reg(REG_LATCH_ON_RISING, d_lor);
			write_reg(REG_COUNT_ENABLE, d_ce);
			write_reg(REG_DEBOUNCE_THRESHOLD, d_thr);
			if (ph_unusd[ph])
				write_reg(REG_UNUSED, 8'($urandom));
			ph_thr   = d_thr;
			gen_left = 0;
			for (n = 0; n < ph_items[ph]; n++)
				send_word(rand_word(), 1'b0, '0);
		end

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0 && status_q.size() == 0)
			$display("tb_debounced_input_latch_counter OK");
		else
			$display("tb_debounced_input_latch_counter NOT OK");
		$finish;
	end

endmodule
